[rtl/blfl_pkg.sv]
// ----------------------------------------------------------------------------
// blfl_pkg
// shared constants, types and helpers of the binary fact layer learner
// ----------------------------------------------------------------------------
package blfl_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int MAX_FACTS    = 64;
    localparam int LAYER_SLOTS  = 3;
    localparam int ROW_W        = (MAX_FEATURES > MAX_FACTS) ? MAX_FEATURES : MAX_FACTS;
    localparam int STORE_DEPTH  = LAYER_SLOTS * MAX_FACTS * ROW_W;
    localparam int LAY_W        = 2;
    localparam int ROW_IW       = $clog2(MAX_FACTS);
    localparam int COL_IW       = $clog2(ROW_W);
    localparam int ADDR_W       = LAY_W + ROW_IW + COL_IW;
    localparam int CNT_W        = COL_IW + 1;

    localparam logic [1:0] OP_PREDICT = 2'd0;
    localparam logic [1:0] OP_LABEL   = 2'd1;
    localparam logic [1:0] OP_REWARD  = 2'd2;
    localparam logic [1:0] OP_INIT    = 2'd3;

    localparam logic [1:0] REW_GOOD = 2'b01;
    localparam logic [1:0] REW_BAD  = 2'b11;

    localparam logic [2:0] REG_DEPTH_LIMIT   = 3'd0;
    localparam logic [2:0] REG_FEATURE_COUNT = 3'd1;
    localparam logic [2:0] REG_LAYER_COUNT   = 3'd2;
    localparam logic [2:0] REG_LAYER0_SIZE   = 3'd3;
    localparam logic [2:0] REG_LAYER1_SIZE   = 3'd4;
    localparam logic [2:0] REG_LAYER2_SIZE   = 3'd5;
    localparam logic [2:0] REG_SEED          = 3'd6;

    typedef struct packed {
        logic [7:0]  depth_limit;
        logic [1:0]  layers;
        logic [5:0]  rows_m1_2;
        logic [5:0]  rows_m1_1;
        logic [5:0]  rows_m1_0;
        logic [5:0]  inputs_m1_0;
        logic [63:0] seed;
    } cfg_t;

    function automatic logic [5:0] clamp_m1(input logic [6:0] v, input logic [6:0] hi);
        logic [5:0] r;
        if (v == 7'd0)
            r = 6'd0;
        else if (v > hi)
            r = 6'(hi - 7'd1);
        else
            r = 6'(v - 7'd1);
        return r;
    endfunction

    function automatic logic [63:0] xorshift(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    function automatic logic [5:0] scale_pick(input logic [31:0] r, input logic [5:0] max);
        logic [38:0] p;
        p = 39'(r) * 39'({1'b0, max} + 7'd1);
        return p[37:32];
    endfunction

endpackage

[rtl/blfl_ram.sv]
// ----------------------------------------------------------------------------
// blfl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module blfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/blfl_rng.sv]
// ----------------------------------------------------------------------------
// blfl_rng
// xorshift64 generator, loaded from the seed and stepped on request
// ----------------------------------------------------------------------------
module blfl_rng (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [63:0] seed,
    input  logic        step,
    output logic [63:0] nxt
);

    logic [63:0] state_reg;

    assign nxt = blfl_pkg::xorshift(state_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 64'd1;
        end
        else if (load)
        begin
            state_reg <= (seed == 64'd0) ? 64'd1 : seed;
        end
        else if (step)
        begin
            state_reg <= nxt;
        end
    end

endmodule

[rtl/blfl_cfg.sv]
// ----------------------------------------------------------------------------
// blfl_cfg
// apb register file with clamped size views for the sequencer
// ----------------------------------------------------------------------------
module blfl_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output blfl_pkg::cfg_t     cfg
);

    logic [7:0]  depth_limit_reg;
    logic [6:0]  feature_count_reg;
    logic [1:0]  layer_count_reg;
    logic [6:0]  layer0_size_reg;
    logic [6:0]  layer1_size_reg;
    logic [6:0]  layer2_size_reg;
    logic [63:0] seed_reg;
    logic [2:0]  idx;
    logic        wr;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg   <= 8'd8;
            feature_count_reg <= 7'd64;
            layer_count_reg   <= 2'd3;
            layer0_size_reg   <= 7'd64;
            layer1_size_reg   <= 7'd64;
            layer2_size_reg   <= 7'd16;
            seed_reg          <= 64'd1;
        end
        else if (wr)
        begin
            case (idx)
                blfl_pkg::REG_DEPTH_LIMIT:   depth_limit_reg   <= pwdata[7:0];
                blfl_pkg::REG_FEATURE_COUNT: feature_count_reg <= pwdata[6:0];
                blfl_pkg::REG_LAYER_COUNT:   layer_count_reg   <= pwdata[1:0];
                blfl_pkg::REG_LAYER0_SIZE:   layer0_size_reg   <= pwdata[6:0];
                blfl_pkg::REG_LAYER1_SIZE:   layer1_size_reg   <= pwdata[6:0];
                blfl_pkg::REG_LAYER2_SIZE:   layer2_size_reg   <= pwdata[6:0];
                blfl_pkg::REG_SEED:          seed_reg          <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            blfl_pkg::REG_DEPTH_LIMIT:   prdata = {56'd0, depth_limit_reg};
            blfl_pkg::REG_FEATURE_COUNT: prdata = {57'd0, feature_count_reg};
            blfl_pkg::REG_LAYER_COUNT:   prdata = {62'd0, layer_count_reg};
            blfl_pkg::REG_LAYER0_SIZE:   prdata = {57'd0, layer0_size_reg};
            blfl_pkg::REG_LAYER1_SIZE:   prdata = {57'd0, layer1_size_reg};
            blfl_pkg::REG_LAYER2_SIZE:   prdata = {57'd0, layer2_size_reg};
            blfl_pkg::REG_SEED:          prdata = seed_reg;
            default:                     prdata = 64'd0;
        endcase
    end

    always_comb
    begin
        cfg.depth_limit = depth_limit_reg;
        cfg.layers      = (layer_count_reg == 2'd0) ? 2'd1 : layer_count_reg;
        cfg.inputs_m1_0 = blfl_pkg::clamp_m1(feature_count_reg, 7'(blfl_pkg::MAX_FEATURES));
        cfg.rows_m1_0   = blfl_pkg::clamp_m1(layer0_size_reg, 7'(blfl_pkg::MAX_FACTS));
        cfg.rows_m1_1   = blfl_pkg::clamp_m1(layer1_size_reg, 7'(blfl_pkg::MAX_FACTS));
        cfg.rows_m1_2   = blfl_pkg::clamp_m1(layer2_size_reg, 7'(blfl_pkg::MAX_FACTS));
        cfg.seed        = seed_reg;
    end

endmodule

[rtl/binary_fact_layer_learner_unit.sv]
// ----------------------------------------------------------------------------
// binary_fact_layer_learner_unit
// layered fact store learner with xorshift noise, one weight per step
// ----------------------------------------------------------------------------
// usage:
//   the slave stream takes one word per operation: tuser holds the op,
//   tdata holds features, label and reward. the master stream returns one
//   word per operation: prediction, deliberate flags and disagreement.
//   registers are written over the apb port while the block is idle.
//   initialize must be issued first; it writes one weight per cycle.
//   predict reads the store through one ram read port, with a read state
//   and an evaluate state per weight, and a closing state per layer.
//   learning then adjusts the winner row of each layer and adds noise to
//   one random row (two for a bad reward or a wrong label). s_tready is high
//   only while the sequencer is idle; a finished word sits in an output
//   register, so a new word is taken while the receiver stalls, and the
//   sequencer waits at its end until that register frees. reset puts the
//   generator at one and the registers at their defaults; the store is left
//   as it is.
// ----------------------------------------------------------------------------
module binary_fact_layer_learner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // features[63:0], label[69:64], reward[71:70]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // prediction[5:0], deliberate_flags[8:6], disagreement[9]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT_W, S_SC_RD, S_SC_EV, S_LAYER_END, S_PRED_END,
        S_AD_RD, S_AD_EV, S_NZ_PICK, S_NZ_RD, S_NZ_EV, S_DONE
    } state_t;

    blfl_pkg::cfg_t cfg;
    state_t      state_reg;
    logic [1:0]  op_reg;
    logic [63:0] feat_reg;
    logic [5:0]  label_reg;
    logic [1:0]  reward_reg;
    logic [1:0]  lay_reg;
    logic [5:0]  row_reg;
    logic [5:0]  col_reg;
    logic [6:0]  score_reg;
    logic        rowone_reg;
    logic [6:0]  best_reg;
    logic [5:0]  bid_reg;
    logic        bdelib_reg;
    logic [5:0]  win_reg [3];
    logic [2:0]  delib_reg;
    logic [5:0]  pred_reg;
    logic        fb_reg;
    logic        inc_reg;
    logic        neg_reg;
    logic        nz2_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    logic [63:0] rng_nxt;
    logic        rng_step;
    logic        rng_load;
    logic        accept;
    logic [5:0]  rows_m1;
    logic [5:0]  inp_m1;
    logic        col_last;
    logic        row_last;
    logic        lay_last;
    logic        pat;
    logic [7:0]  rdata;
    logic [7:0]  wdata;
    logic        we;
    logic [7:0]  adj_w;
    logic        dec_l;
    logic        nz_hit;
    logic [6:0]  sc_f;
    logic        one_f;
    logic [2:0]  used_mask;
    logic [5:0]  pred_f;
    logic [blfl_pkg::ADDR_W-1:0] addr;

    blfl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blfl_rng u_rng (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (rng_load),
        .seed  (cfg.seed),
        .step  (rng_step),
        .nxt   (rng_nxt)
    );

    blfl_ram #(
        .WIDTH (8),
        .DEPTH (blfl_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (addr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign addr     = {lay_reg, row_reg, col_reg};

    always_comb
    begin
        case (lay_reg)
            2'd0:    begin rows_m1 = cfg.rows_m1_0; inp_m1 = cfg.inputs_m1_0; end
            2'd1:    begin rows_m1 = cfg.rows_m1_1; inp_m1 = cfg.rows_m1_0;   end
            default: begin rows_m1 = cfg.rows_m1_2; inp_m1 = cfg.rows_m1_1;   end
        endcase
        case (cfg.layers)
            2'd1:    used_mask = 3'b001;
            2'd2:    used_mask = 3'b011;
            default: used_mask = 3'b111;
        endcase
    end

    assign col_last = (col_reg == inp_m1);
    assign row_last = (row_reg == rows_m1);
    assign lay_last = (lay_reg == cfg.layers - 2'd1);
    assign pred_f   = win_reg[cfg.layers - 2'd1];

    always_comb
    begin
        if (lay_reg == 2'd0)
            pat = feat_reg[col_reg];
        else if (lay_reg == 2'd2)
            pat = (col_reg == win_reg[1]);
        else
            pat = (col_reg == win_reg[0]);
    end

    assign sc_f  = score_reg + 7'((pat && rdata != 8'd0) ? 1 : 0);
    assign one_f = rowone_reg || (rdata == 8'd1);
    assign dec_l = neg_reg && (!fb_reg || delib_reg[lay_reg]);
    assign nz_hit = nz2_reg ? (rdata == 8'd0) : (rdata == 8'd1);

    always_comb
    begin
        if (pat && inc_reg)
            adj_w = (rdata < cfg.depth_limit) ? rdata + 8'd1 : cfg.depth_limit;
        else if (pat && dec_l)
            adj_w = (rdata > 8'd0) ? rdata - 8'd1 : 8'd0;
        else if (!pat && rdata == 8'd1)
            adj_w = 8'd0;
        else
            adj_w = rdata;
    end

    always_comb
    begin
        we = 1'b0;
        wdata = {7'd0, rng_nxt[0]};
        rng_step = 1'b0;
        case (state_reg)
            S_INIT_W:
            begin
                we = 1'b1;
                rng_step = 1'b1;
            end
            S_AD_EV:
            begin
                we = 1'b1;
                wdata = adj_w;
            end
            S_NZ_PICK: rng_step = (rows_m1 != 6'd0);
            S_NZ_EV:
            begin
                we = nz_hit;
                rng_step = nz_hit;
            end
            default: ;
        endcase
    end

    assign rng_load = accept && (s_tuser == blfl_pkg::OP_INIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            lay_reg       <= 2'd0;
            row_reg       <= 6'd0;
            col_reg       <= 6'd0;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= s_tuser;
                        feat_reg   <= s_tdata[63:0];
                        label_reg  <= s_tdata[69:64];
                        reward_reg <= s_tdata[71:70];
                        lay_reg    <= 2'd0;
                        row_reg    <= 6'd0;
                        col_reg    <= 6'd0;
                        score_reg  <= 7'd0;
                        rowone_reg <= 1'b0;
                        delib_reg  <= 3'd0;
                        pred_reg   <= 6'd0;
                        fb_reg     <= 1'b0;
                        state_reg  <= (s_tuser == blfl_pkg::OP_INIT) ? S_INIT_W : S_SC_RD;
                    end
                end
                S_INIT_W:
                begin
                    if (col_last)
                    begin
                        col_reg <= 6'd0;
                        if (row_last)
                        begin
                            row_reg <= 6'd0;
                            if (lay_last)
                                state_reg <= S_DONE;
                            else
                                lay_reg <= lay_reg + 2'd1;
                        end
                        else
                        begin
                            row_reg <= row_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 6'd1;
                    end
                end
                S_SC_RD: state_reg <= S_SC_EV;
                S_SC_EV:
                begin
                    state_reg <= S_SC_RD;
                    if (col_last)
                    begin
                        col_reg    <= 6'd0;
                        score_reg  <= 7'd0;
                        rowone_reg <= 1'b0;
                        if (row_reg == 6'd0 || sc_f > best_reg)
                        begin
                            best_reg   <= sc_f;
                            bid_reg    <= row_reg;
                            bdelib_reg <= one_f;
                        end
                        if (row_last)
                            state_reg <= S_LAYER_END;
                        else
                            row_reg <= row_reg + 6'd1;
                    end
                    else
                    begin
                        score_reg  <= sc_f;
                        rowone_reg <= one_f;
                        col_reg    <= col_reg + 6'd1;
                    end
                end
                S_LAYER_END:
                begin
                    win_reg[lay_reg]   <= bid_reg;
                    delib_reg[lay_reg] <= bdelib_reg;
                    row_reg <= 6'd0;
                    col_reg <= 6'd0;
                    if (lay_last)
                    begin
                        state_reg <= S_PRED_END;
                    end
                    else
                    begin
                        lay_reg   <= lay_reg + 2'd1;
                        state_reg <= S_SC_RD;
                    end
                end
                S_PRED_END:
                begin
                    pred_reg <= pred_f;
                    fb_reg   <= (delib_reg != 3'd0) && (delib_reg != used_mask);
                    if (op_reg == blfl_pkg::OP_LABEL)
                    begin
                        inc_reg <= (pred_f == label_reg);
                        neg_reg <= (pred_f != label_reg);
                    end
                    else
                    begin
                        inc_reg <= (reward_reg == blfl_pkg::REW_GOOD);
                        neg_reg <= (reward_reg == blfl_pkg::REW_BAD);
                    end
                    lay_reg <= 2'd0;
                    row_reg <= win_reg[0];
                    col_reg <= 6'd0;
                    state_reg <= (op_reg == blfl_pkg::OP_PREDICT) ? S_DONE : S_AD_RD;
                end
                S_AD_RD: state_reg <= S_AD_EV;
                S_AD_EV:
                begin
                    if (col_last)
                    begin
                        nz2_reg   <= 1'b0;
                        state_reg <= S_NZ_PICK;
                    end
                    else
                    begin
                        col_reg   <= col_reg + 6'd1;
                        state_reg <= S_AD_RD;
                    end
                end
                S_NZ_PICK:
                begin
                    row_reg <= (rows_m1 == 6'd0) ? 6'd0
                             : blfl_pkg::scale_pick(rng_nxt[31:0], rows_m1);
                    col_reg <= 6'd0;
                    state_reg <= S_NZ_RD;
                end
                S_NZ_RD: state_reg <= S_NZ_EV;
                S_NZ_EV:
                begin
                    if (col_last)
                    begin
                        col_reg <= 6'd0;
                        if (!nz2_reg && neg_reg)
                        begin
                            nz2_reg   <= 1'b1;
                            state_reg <= S_NZ_PICK;
                        end
                        else if (lay_last)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            lay_reg   <= lay_reg + 2'd1;
                            row_reg   <= win_reg[lay_reg + 2'd1];
                            state_reg <= S_AD_RD;
                        end
                    end
                    else
                    begin
                        col_reg   <= col_reg + 6'd1;
                        state_reg <= S_NZ_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'd0, fb_reg, delib_reg, pred_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/blfl_checker.sv]
// ----------------------------------------------------------------------------
// blfl_checker
// port level checks of the learner, bound to the top level
// ----------------------------------------------------------------------------
module blfl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // one word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled word changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:10] == 6'd0)
        else $error("padding bits set");

    a_disagree_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] |-> m_tdata[8:6] != 3'd0)
        else $error("disagreement without any flag");

endmodule

bind binary_fact_layer_learner_unit blfl_checker u_blfl_checker (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stream and apb testbench for the binary fact layer learner unit: a local
// copy of the fact store, the xorshift generator and the configuration
// predicts every result word; directed words at full and extreme sizes,
// then random phases of mostly learning words at small sizes
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] REW_NONE = 2'b00;
    localparam logic [1:0] REW_ODD  = 2'b10;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [5:0] prediction;
        logic [2:0] flags;
        logic       disagree;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // features[63:0], label[69:64], reward[71:70]
    logic [1:0]  s_tuser = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // prediction[5:0], deliberate_flags[8:6], disagreement[9]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    binary_fact_layer_learner_unit dut (.*);

    always #5 clk = ~clk;

    // local copy of the learner
    logic [7:0]  fact_wt [3][64][64];
    logic [63:0] gen_state;
    logic [7:0]  c_depth;
    logic [6:0]  c_feat, c_l0, c_l1, c_l2;
    logic [1:0]  c_layers;
    logic [63:0] c_seed;

    verdict_t    pending_results[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          words_seen = 0;
    int          learn_words = 0;
    int          init_words = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;

    function automatic int unsigned clamp64(logic [6:0] v);
        return v == 0 ? 1 : (v > 64 ? 64 : int'(v));
    endfunction

    function automatic int unsigned rows_in(int l);
        return clamp64(l == 0 ? c_l0 : (l == 1 ? c_l1 : c_l2));
    endfunction

    function automatic int unsigned inputs_in(int l);
        return l == 0 ? clamp64(c_feat) : rows_in(l - 1);
    endfunction

    function automatic logic [31:0] gen_draw();
        gen_state = gen_state ^ (gen_state << 13);
        gen_state = gen_state ^ (gen_state >> 7);
        gen_state = gen_state ^ (gen_state << 17);
        return gen_state[31:0];
    endfunction

    function automatic logic [7:0] gen_bit();
        logic [31:0] d;
        d = gen_draw();
        return {7'd0, d[0]};
    endfunction

    function automatic int unsigned gen_pick(int unsigned mx);
        logic [63:0] p;
        if (mx == 0) return 0;
        p = 64'(gen_draw()) * (64'(mx) + 64'd1);
        return p[63:32];
    endfunction

    function automatic void apply_noise(int l, int rw);
        int unsigned n, r;
        n = inputs_in(l);
        r = gen_pick(rows_in(l) - 1);
        for (int i = 0; i < n; i++)
            if (fact_wt[l][r][i] == 8'd1) fact_wt[l][r][i] = gen_bit();
        if (rw == -1) begin
            r = gen_pick(rows_in(l) - 1);
            for (int i = 0; i < n; i++)
                if (fact_wt[l][r][i] == 8'd0) fact_wt[l][r][i] = gen_bit();
        end
    endfunction

    function automatic void adjust_row(int l, int row, logic [63:0] pat, bit dl, int rw, bit fb);
        bit inc, dec;
        inc = rw == 1;
        dec = rw == -1 && (!fb || dl);
        for (int i = 0; i < inputs_in(l); i++) begin
            if (pat[i] && inc)
                fact_wt[l][row][i] = fact_wt[l][row][i] < c_depth ? fact_wt[l][row][i] + 8'd1
                                                                  : c_depth;
            else if (pat[i] && dec)
                fact_wt[l][row][i] = fact_wt[l][row][i] > 0 ? fact_wt[l][row][i] - 8'd1 : 8'd0;
            else if (!pat[i] && fact_wt[l][row][i] == 8'd1)
                fact_wt[l][row][i] = 8'd0;
        end
        apply_noise(l, rw);
    endfunction

    function automatic verdict_t learner_step(logic [1:0] op, logic [63:0] feat,
                                              logic [5:0] label, logic [1:0] rbits);
        verdict_t    v;
        int          nl, best, score, rw;
        int          win [3];
        logic [63:0] pats [3];
        bit          dl [3];
        bit          fb;
        v = '0;
        fb = 0;
        nl = c_layers == 0 ? 1 : int'(c_layers);
        if (op == blfl_pkg::OP_INIT) begin
            gen_state = c_seed == 0 ? 64'd1 : c_seed;
            for (int l = 0; l < nl; l++)
                for (int r = 0; r < rows_in(l); r++)
                    for (int i = 0; i < inputs_in(l); i++)
                        fact_wt[l][r][i] = gen_bit();
            return v;
        end
        pats[0] = feat;
        for (int l = 0; l < nl; l++) begin
            best = -1;
            win[l] = 0;
            for (int r = 0; r < rows_in(l); r++) begin
                score = 0;
                for (int i = 0; i < inputs_in(l); i++)
                    if (pats[l][i] && fact_wt[l][r][i] != 0) score++;
                if (score > best) begin
                    best = score;
                    win[l] = r;
                end
            end
            dl[l] = 0;
            for (int i = 0; i < inputs_in(l); i++)
                if (fact_wt[l][win[l]][i] == 8'd1) dl[l] = 1;
            v.flags[l] = dl[l];
            if (dl[l] != dl[0]) fb = 1;
            if (l < 2) pats[l + 1] = 64'd1 << win[l];
        end
        v.prediction = 6'(win[nl - 1]);
        v.disagree = fb;
        if (op == blfl_pkg::OP_LABEL || op == blfl_pkg::OP_REWARD) begin
            if (op == blfl_pkg::OP_LABEL)
                rw = v.prediction == label ? 1 : -1;
            else
                rw = rbits[1] ? int'(rbits) - 4 : int'(rbits);
            for (int l = 0; l < nl; l++)
                adjust_row(l, win[l], pats[l], dl[l], rw, fb);
        end
        return v;
    endfunction

    // result checking and watchdog
    always @(posedge clk) begin
        verdict_t exp_v;
        if (m_tvalid && m_tready) begin
            words_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: unexpected result word %h", m_tdata);
            end else begin
                exp_v = pending_results.pop_front();
                if (m_tdata[5:0] !== exp_v.prediction || m_tdata[8:6] !== exp_v.flags ||
                    m_tdata[9] !== exp_v.disagree) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("error: word %0d pred %0d/%0d flags %b/%b disagree %b/%b",
                                 words_seen, m_tdata[5:0], exp_v.prediction, m_tdata[8:6],
                                 exp_v.flags, m_tdata[9], exp_v.disagree);
                end
            end
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern
    int rx_mode = 0;
    int rx_left = 0;
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(5, 60);
        end else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            blfl_pkg::REG_DEPTH_LIMIT:   c_depth = val[7:0];
            blfl_pkg::REG_FEATURE_COUNT: c_feat = val[6:0];
            blfl_pkg::REG_LAYER_COUNT:   c_layers = val[1:0];
            blfl_pkg::REG_LAYER0_SIZE:   c_l0 = val[6:0];
            blfl_pkg::REG_LAYER1_SIZE:   c_l1 = val[6:0];
            blfl_pkg::REG_LAYER2_SIZE:   c_l2 = val[6:0];
            blfl_pkg::REG_SEED:          c_seed = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] depth, logic [6:0] feat, logic [1:0] layers,
                              logic [6:0] l0, logic [6:0] l1, logic [6:0] l2,
                              logic [63:0] sd);
        write_reg(blfl_pkg::REG_DEPTH_LIMIT, 64'(depth));
        write_reg(blfl_pkg::REG_FEATURE_COUNT, 64'(feat));
        write_reg(blfl_pkg::REG_LAYER_COUNT, 64'(layers));
        write_reg(blfl_pkg::REG_LAYER0_SIZE, 64'(l0));
        write_reg(blfl_pkg::REG_LAYER1_SIZE, 64'(l1));
        write_reg(blfl_pkg::REG_LAYER2_SIZE, 64'(l2));
        write_reg(blfl_pkg::REG_SEED, sd);
    endtask

    task automatic send_word(logic [1:0] op, logic [63:0] feat, logic [5:0] label,
                             logic [1:0] rbits);
        int gap;
        verdict_t v;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {rbits, label, feat};
        do @(posedge clk); while (!s_tready);
        v = learner_step(op, feat, label, rbits);
        pending_results.insert(pending_results.size(), v);
        words_sent++;
        if (op == blfl_pkg::OP_INIT) init_words++;
        if (op == blfl_pkg::OP_LABEL || op == blfl_pkg::OP_REWARD) learn_words++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_features();
        logic [63:0] f;
        f = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: f = f & {$urandom, $urandom};
            1: f = f | {$urandom, $urandom};
            default: ;
        endcase
        return f;
    endfunction

    task automatic test_full_size();
        set_config(8'd8, 7'd64, 2'd3, 7'd64, 7'd64, 7'd64, 64'd1);
        send_word(blfl_pkg::OP_INIT, '0, '0, REW_NONE);
        send_word(blfl_pkg::OP_PREDICT, '0, '0, REW_NONE);
        send_word(blfl_pkg::OP_PREDICT, '1, '1, blfl_pkg::REW_GOOD);
        send_word(blfl_pkg::OP_LABEL, '1, 6'd0, REW_NONE);
        send_word(blfl_pkg::OP_LABEL, 64'hA5A5_5A5A_F0F0_0F0F, 6'd63, blfl_pkg::REW_BAD);
        send_word(blfl_pkg::OP_REWARD, 64'h8000_0000_0000_0001, '0, blfl_pkg::REW_GOOD);
        send_word(blfl_pkg::OP_REWARD, 64'h0123_4567_89AB_CDEF, '0, blfl_pkg::REW_BAD);
        send_word(blfl_pkg::OP_REWARD, '1, '0, REW_NONE);
        send_word(blfl_pkg::OP_REWARD, 64'hFFFF_0000_FFFF_0000, '0, REW_ODD);
        drain();
    endtask

    task automatic test_extremes();
        // tiny sizes with out of range counts, store kept from the full fill
        set_config(8'd0, 7'd0, 2'd0, 7'd0, 7'd1, 7'd1, 64'd0);
        send_word(blfl_pkg::OP_REWARD, '1, '0, blfl_pkg::REW_GOOD);
        send_word(blfl_pkg::OP_LABEL, 64'h2, 6'd0, REW_NONE);
        send_word(blfl_pkg::OP_INIT, '0, '0, REW_NONE);
        send_word(blfl_pkg::OP_REWARD, '1, '0, blfl_pkg::REW_GOOD);
        send_word(blfl_pkg::OP_PREDICT, '1, '0, REW_NONE);
        drain();
        set_config(8'd255, 7'd127, 2'd1, 7'd2, 7'd127, 7'd127, '1);
        send_word(blfl_pkg::OP_INIT, '0, '0, REW_NONE);
        for (int k = 0; k < 6; k++) send_word(blfl_pkg::OP_REWARD, '1, '0, blfl_pkg::REW_GOOD);
        send_word(blfl_pkg::OP_LABEL, 64'h1, 6'd1, REW_NONE);
        send_word(blfl_pkg::OP_REWARD, '0, '0, blfl_pkg::REW_BAD);
        drain();
        set_config(8'd1, 7'd3, 2'd2, 7'd3, 7'd64, 7'd4, 64'hDEAD_BEEF_0000_0001);
        send_word(blfl_pkg::OP_PREDICT, 64'hFFFF_FFFF_FFFF_FFF8, '0, REW_NONE);
        send_word(blfl_pkg::OP_LABEL, 64'h7, 6'd2, REW_NONE);
        drain();
    endtask

    task automatic test_random_phases();
        int n_items;
        logic [1:0]  op;
        logic [5:0]  label;
        int unsigned pick_op;
        logic [6:0]  last_rows;
        for (int ph = 0; ph < 8; ph++) begin
            set_config($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255)),
                       $urandom_range(0, 9) == 0 ? 7'($urandom_range(65, 127))
                                                 : 7'($urandom_range(1, 10)),
                       2'($urandom_range(0, 3)),
                       7'($urandom_range(0, 8)), 7'($urandom_range(1, 8)),
                       7'($urandom_range(1, 8)),
                       $urandom_range(0, 7) == 0 ? 64'd0 : {$urandom, $urandom});
            if (ph != 3) send_word(blfl_pkg::OP_INIT, '0, '0, REW_NONE);
            last_rows = c_layers <= 1 ? c_l0 : (c_layers == 2 ? c_l1 : c_l2);
            n_items = 112;
            for (int k = 0; k < n_items; k++) begin
                pick_op = $urandom_range(0, 99);
                op = pick_op < 45 ? blfl_pkg::OP_LABEL : pick_op < 75 ? blfl_pkg::OP_REWARD :
                     pick_op < 96 ? blfl_pkg::OP_PREDICT : blfl_pkg::OP_INIT;
                label = $urandom_range(0, 4) == 0 ? 6'($urandom)
                        : 6'($urandom_range(0, clamp64(last_rows) - 1));
                send_word(op, rand_features(), label, 2'($urandom));
                if (k == n_items / 2) drain();
            end
            drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        c_depth = 8'd8;
        c_feat = 7'd64;
        c_layers = 2'd3;
        c_l0 = 7'd64;
        c_l1 = 7'd64;
        c_l2 = 7'd16;
        c_seed = 64'd1;
        gen_state = 64'd1;
        test_full_size();
        test_extremes();
        test_random_phases();
        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d words (%0d learning, %0d initialize) over full, extreme",
                 words_sent, learn_words, init_words);
        $display("and random small layer configurations, %0d results checked", words_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
